// ===== design/trf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants of the trace record framer
// Command and register codes, request and result payloads, sequencer states
// and the control group between the sequencer and the ring store.
// ----------------------------------------------------------------------------
package trf_pkg;

  // default sizes
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_READ_DEF    = 64;

  // command codes
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_BEGIN = 3'd1;
  localparam logic [2:0] CMD_DATA  = 3'd2;
  localparam logic [2:0] CMD_END   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_FLAG   = 3'd0;
  localparam logic [2:0] REG_ESC    = 3'd1;
  localparam logic [2:0] REG_MASK   = 3'd2;
  localparam logic [2:0] REG_CKS_EN = 3'd3;
  localparam logic [2:0] REG_SEQ_EN = 3'd4;
  localparam logic [2:0] REG_STAMP  = 3'd5;

  // request payload
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  event_id;
    logic [31:0] stamp;
    logic [31:0] payload;
    logic [2:0]  payload_bytes;
    logic [6:0]  read_request;
  } trf_in_t;

  // result payload
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        last;
    logic [10:0] stored_count;
  } trf_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_BOOT,
    ST_IDLE,
    ST_STUFF,
    ST_ESC2,
    ST_FLAG,
    ST_READ,
    ST_DONE
  } trf_state_t;

  // sequencer to ring store control
  typedef struct packed {
    logic       clear;
    logic       wr_en;
    logic [7:0] wr_byte;
    logic       rd_en;
  } trf_ring_ctl_t;

  // timestamp size: only 0, 1 and 4 stand as given, all else is 2
  function automatic logic [2:0] trf_stamp_len(input logic [2:0] sb);
    logic [2:0] len;
    unique case (sb)
      3'd0:    len = 3'd0;
      3'd1:    len = 3'd1;
      3'd4:    len = 3'd4;
      default: len = 3'd2;
    endcase
    return len;
  endfunction

endpackage

// ===== design/trace_record_framer_ring_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_record_framer_ring_top: trace record framer over a circular store
// A request is taken when start is high and busy is low; busy stays high
// until the request's work is finished. Commands: init, begin record, data,
// end record and read. Each byte goes through one stuffing unit and is
// written into the store at one byte per cycle; an escaped byte is written
// as the escape byte, then the masked byte. Begin, data, end and init each
// give a single result that shows on out_strobe in the first cycle with busy
// low. A read of n bytes issues one store read per cycle; each byte passes
// the store's read register and the result register, one per cycle with
// last on the final one; a read of no bytes gives one result. Results cannot
// be held off: each is marked by out_strobe for one cycle only. Configuration
// writes on cfg_we take effect at once; the user makes them while idle, and
// the block itself does not enforce this. After reset the boot state writes
// the frame flag into store entry 0, then is ready with one byte held.
// ----------------------------------------------------------------------------
module trace_record_framer_ring_top
  import trf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_READ    = MAX_READ_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  trf_in_t    in_data,
  output logic       out_strobe,
  output trf_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int HW = $clog2(STORE_DEPTH + 1);
  localparam int RW = $clog2(MAX_READ + 1);
  localparam int MW = (HW > 7) ? HW : 7;

  // configuration registers
  logic [7:0] flag_r, esc_r, mask_r;
  logic       cks_en_r, seq_en_r;
  logic [2:0] stamp_r;

  // sequencer state
  trf_state_t    state_r, state_nxt;
  trf_ring_ctl_t ctl;
  logic          accept;
  logic [47:0]   queue_r;
  logic [2:0]    cnt_r;
  logic          flag_after_r;
  logic [7:0]    sum_r, seq_r;
  logic [RW-1:0] rcnt_r;
  logic          q_shift, sum_ld;

  // read path
  logic          rd_pend_r, rd_last_r;
  logic          out_strobe_r;
  trf_out_t      out_data_r;

  // shared unit and store connections
  logic          need_esc;
  logic [7:0]    masked, sum_out, rdata;
  logic [HW-1:0] held, to_end;
  logic [MW-1:0] to_end_w, held_w, req_w, n_w;
  logic [2:0]    slen, plen;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= 8'd126;
      esc_r    <= 8'd125;
      mask_r   <= 8'd32;
      cks_en_r <= 1'b1;
      seq_en_r <= 1'b1;
      stamp_r  <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAG:   flag_r   <= cfg_wdata;
        REG_ESC:    esc_r    <= cfg_wdata;
        REG_MASK:   mask_r   <= cfg_wdata;
        REG_CKS_EN: cks_en_r <= cfg_wdata[0];
        REG_SEQ_EN: seq_en_r <= cfg_wdata[0];
        REG_STAMP:  stamp_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // shared stuffing unit
  trf_stuff u_stuff (
    .data_in      (queue_r[7:0]),
    .flag_value   (flag_r),
    .escape_value (esc_r),
    .stuff_mask   (mask_r),
    .sum_in       (sum_r),
    .need_esc     (need_esc),
    .masked       (masked),
    .sum_out      (sum_out)
  );

  // circular store
  trf_ring #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rdata  (rdata),
    .held   (held),
    .to_end (to_end)
  );

  // drain length: least of bytes to store end, held bytes and clamped request
  always_comb begin
    to_end_w = MW'(to_end);
    held_w   = MW'(held);
    req_w    = (in_data.read_request > 7'(MAX_READ)) ? MW'(MAX_READ)
                                                     : MW'(in_data.read_request);
    n_w = to_end_w;
    if (held_w < n_w) begin
      n_w = held_w;
    end
    if (req_w < n_w) begin
      n_w = req_w;
    end
  end

  // byte counts of begin and data
  assign slen = trf_stamp_len(stamp_r);
  assign plen = (in_data.payload_bytes > 3'd4) ? 3'd4 : in_data.payload_bytes;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_BOOT: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.cmd)
            CMD_INIT:  state_nxt = ST_FLAG;
            CMD_BEGIN: state_nxt = ST_STUFF;
            CMD_DATA:  state_nxt = ST_STUFF;
            CMD_END:   state_nxt = ST_STUFF;
            CMD_READ:  state_nxt = (n_w == '0) ? ST_DONE : ST_READ;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_STUFF: begin
        if (cnt_r == 3'd0) begin
          state_nxt = flag_after_r ? ST_FLAG : ST_DONE;
        end else if (need_esc) begin
          state_nxt = ST_ESC2;
        end
      end
      ST_ESC2: state_nxt = ST_STUFF;
      ST_FLAG: state_nxt = ST_DONE;
      ST_READ: begin
        if (rcnt_r == RW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl     = '0;
    q_shift = 1'b0;
    sum_ld  = 1'b0;
    unique case (state_r)
      ST_BOOT: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = flag_r;
      end
      ST_IDLE: begin
        ctl.clear = accept && (in_data.cmd == CMD_INIT);
      end
      ST_STUFF: begin
        if (cnt_r != 3'd0) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_byte = need_esc ? esc_r : queue_r[7:0];
          sum_ld      = 1'b1;
          q_shift     = !need_esc;
        end
      end
      ST_ESC2: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = masked;
        q_shift     = 1'b1;
      end
      ST_FLAG: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = flag_r;
      end
      ST_READ: begin
        ctl.rd_en = 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // byte queue, checksum and sequence number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      seq_r <= '0;
    end else if (accept) begin
      unique case (in_data.cmd)
        CMD_INIT: seq_r <= '0;
        CMD_BEGIN: begin
          sum_r <= '0;
          if (seq_en_r) begin
            seq_r <= seq_r + 8'd1;
          end
        end
        CMD_END: begin
          if (cks_en_r) begin
            sum_r <= 8'd0 - sum_r;
          end
        end
        default: ;
      endcase
    end else if (sum_ld) begin
      sum_r <= sum_out;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flag_after_r <= 1'b0;
      unique case (in_data.cmd)
        CMD_BEGIN: begin
          if (seq_en_r) begin
            queue_r <= {in_data.stamp, seq_r, in_data.event_id};
            cnt_r   <= 3'(3'd2 + slen);
          end else begin
            queue_r <= {8'd0, in_data.stamp, in_data.event_id};
            cnt_r   <= 3'(3'd1 + slen);
          end
        end
        CMD_DATA: begin
          queue_r <= {16'd0, in_data.payload};
          cnt_r   <= plen;
        end
        CMD_END: begin
          queue_r      <= {40'd0, 8'd0 - sum_r};
          cnt_r        <= {2'b00, cks_en_r};
          flag_after_r <= 1'b1;
        end
        CMD_READ: rcnt_r <= RW'(n_w);
        default: ;
      endcase
    end else begin
      if (q_shift) begin
        queue_r <= {8'd0, queue_r[47:8]};
        cnt_r   <= cnt_r - 3'd1;
      end
      if (ctl.rd_en) begin
        rcnt_r <= rcnt_r - 1'b1;
      end
    end
  end

  // result register, store read data arrives in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      rd_last_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      rd_pend_r    <= ctl.rd_en;
      rd_last_r    <= ctl.rd_en && (rcnt_r == RW'(1));
      out_strobe_r <= rd_pend_r || (state_r == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_data_r <= '{out_byte: rdata, out_valid: 1'b1, last: rd_last_r,
                      stored_count: 11'(held)};
    end else begin
      out_data_r <= '{out_byte: 8'd0, out_valid: 1'b0, last: 1'b1,
                      stored_count: 11'(held)};
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== design/trf_stuff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_stuff: byte stuffing and checksum unit
// Decides whether a byte needs an escape, forms the masked byte and adds the
// byte into the running checksum. Shared by every stuffed byte of a record.
// ----------------------------------------------------------------------------
module trf_stuff
  import trf_pkg::*;
(
  input  logic [7:0] data_in,
  input  logic [7:0] flag_value,
  input  logic [7:0] escape_value,
  input  logic [7:0] stuff_mask,
  input  logic [7:0] sum_in,
  output logic       need_esc,
  output logic [7:0] masked,
  output logic [7:0] sum_out
);

  // escape match against the delimiter and the escape byte itself
  assign need_esc = (data_in == flag_value) || (data_in == escape_value);

  // second byte of an escape pair
  assign masked = data_in ^ stuff_mask;

  // modulo 256 checksum
  assign sum_out = sum_in + data_in;

endmodule

// ===== design/trf_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_ring: circular byte store with overwrite of the oldest byte
// One write and one registered read per cycle, write and read indexes and
// the held byte count. A write into a full store pushes the read index along.
// ----------------------------------------------------------------------------
module trf_ring
  import trf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trf_ring_ctl_t                     ctl,
  output logic [7:0]                        rdata,
  output logic [$clog2(STORE_DEPTH+1)-1:0]  held,
  output logic [$clog2(STORE_DEPTH+1)-1:0]  to_end
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int HW = $clog2(STORE_DEPTH + 1);

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rdata_r;
  logic [IW-1:0] wr_r, wr_nxt, wr_inc;
  logic [IW-1:0] rd_r, rd_nxt, rd_inc;
  logic [HW-1:0] held_r, held_nxt;

  // index increments with wrap at the store end
  assign wr_inc = (wr_r == IW'(STORE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == IW'(STORE_DEPTH - 1)) ? '0 : rd_r + 1'b1;

  // index and count update
  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    held_nxt = held_r;
    if (ctl.clear) begin
      wr_nxt   = '0;
      rd_nxt   = '0;
      held_nxt = '0;
    end else if (ctl.wr_en) begin
      wr_nxt = wr_inc;
      if (held_r >= HW'(STORE_DEPTH - 1)) begin
        held_nxt = HW'(STORE_DEPTH);
        rd_nxt   = wr_inc;
      end else begin
        held_nxt = held_r + 1'b1;
      end
    end else if (ctl.rd_en) begin
      rd_nxt   = rd_inc;
      held_nxt = held_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      held_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      held_r <= held_nxt;
    end
  end

  // store array, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_r] <= ctl.wr_byte;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_r];
    end
  end

  assign rdata  = rdata_r;
  assign held   = held_r;
  assign to_end = HW'(STORE_DEPTH) - HW'(rd_r);

endmodule

// ===== design/trf_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_chk: port checker of the trace record framer
// Watches the result ports for result ordering and framing.
// ----------------------------------------------------------------------------
module trf_chk
  import trf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_strobe,
  input trf_out_t out_data
);

  // a result without a byte is always the only and final one
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.out_valid |-> out_data.last)
    else $error("empty result not marked last");

  // a result without a byte carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("empty result with nonzero byte");

  // a drain runs without gaps until its last byte
  a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.out_valid && !out_data.last
      |=> out_strobe && out_data.out_valid)
    else $error("gap inside a drain");

  // the final result of a request is never directly followed by a drained byte
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last |=> !(out_strobe && out_data.out_valid))
    else $error("drained byte right after a final result");

  // each byte of a drain leaves one fewer held byte
  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.out_valid && !out_data.last
      |=> out_data.stored_count == $past(out_data.stored_count) - 11'd1)
    else $error("held count not stepping down during a drain");

endmodule

bind trace_record_framer_ring_top trf_chk u_trf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
